[rtl/core/lbc_pkg.sv]
package lbc_pkg;

    localparam int FRAC_BITS = 8;
    localparam int ANG_BITS  = 20;
    localparam int ANG_SHIFT = ANG_BITS - FRAC_BITS;
    localparam int MUL_SHIFT = 30;

    localparam int LATQ_W = 18;
    localparam int PROJ_W = 25;
    localparam int CX_W   = 33;
    localparam int CS_W   = 32;
    localparam int AZ_W   = 30;
    localparam int AX_W   = 57;
    localparam int PROD_W = PROJ_W + CS_W;
    localparam int XS_W   = PROD_W - MUL_SHIFT;
    localparam int DX_W   = 25;
    localparam int DY_W   = 24;
    localparam int BRG_W  = 17;
    localparam int DEV_W  = 15;
    localparam int CLS_W  = 3;

    localparam logic signed [CX_W-1:0]  GAIN_Q30  = 33'sd652032875;
    localparam logic signed [AZ_W-1:0]  Z_NINETY  = 30'sd94371840;
    localparam logic signed [AZ_W-1:0]  Z_ONE80   = 30'sd188743680;
    localparam logic signed [BRG_W-1:0] B_NINETY  = 17'sd23040;
    localparam logic signed [BRG_W-1:0] B_ONE80   = 17'sd46080;
    localparam logic signed [PROJ_W-1:0] KM_PER_DEG = 25'sd111;

    // Register indices of the configuration port.
    typedef enum logic [1:0] {
        REG_REF_LAT_DEG = 2'd0,
        REG_REF_LAT_MIN = 2'd1,
        REG_REF_LON_DEG = 2'd2,
        REG_REF_LON_MIN = 2'd3
    } reg_index_t;

    localparam logic [CLS_W-1:0] CLS_N  = 3'd0;
    localparam logic [CLS_W-1:0] CLS_E  = 3'd1;
    localparam logic [CLS_W-1:0] CLS_W_ = 3'd2;
    localparam logic [CLS_W-1:0] CLS_S  = 3'd3;
    localparam logic [CLS_W-1:0] CLS_NW = 3'd4;
    localparam logic [CLS_W-1:0] CLS_NE = 3'd5;
    localparam logic [CLS_W-1:0] CLS_SE = 3'd6;
    localparam logic [CLS_W-1:0] CLS_SW = 3'd7;

    typedef struct packed {
        logic signed [CX_W-1:0]   x;
        logic signed [CX_W-1:0]   y;
        logic signed [AZ_W-1:0]   z;
        logic                     neg;
        logic signed [PROJ_W-1:0] lon111;
        logic signed [PROJ_W-1:0] yp;
    } cos_lane_t;

    typedef struct packed {
        logic signed [AX_W-1:0]  x;
        logic signed [AX_W-1:0]  y;
        logic signed [AZ_W-1:0]  z;
        logic signed [DX_W-1:0]  dx;
        logic signed [DY_W-1:0]  dy;
        logic                    spec;
        logic signed [BRG_W-1:0] sb;
    } atan_lane_t;

    // Degrees plus minutes/60 rounded half up; the division by 60 is a
    // reciprocal multiply that is exact over the six-bit minute range.
    function automatic logic signed [LATQ_W-1:0] to_angle(input logic signed [8:0] deg,
                                                          input logic [5:0] mins);
        logic [13:0] n;
        logic [28:0] p;
        logic [8:0]  frac;
        n    = {mins, {FRAC_BITS{1'b0}}} + 14'd30;
        p    = 29'(n) * 29'd17477;
        frac = p[28:20];
        to_angle = $signed({deg[8], deg, {FRAC_BITS{1'b0}}}) + $signed({9'b0, frac});
    endfunction

    function automatic logic signed [AZ_W-1:0] atan_q20(input logic [4:0] k);
        case (k)
            5'd0:    atan_q20 = 30'sd47185920;
            5'd1:    atan_q20 = 30'sd27855475;
            5'd2:    atan_q20 = 30'sd14718068;
            5'd3:    atan_q20 = 30'sd7471121;
            5'd4:    atan_q20 = 30'sd3750058;
            5'd5:    atan_q20 = 30'sd1876857;
            5'd6:    atan_q20 = 30'sd938658;
            5'd7:    atan_q20 = 30'sd469357;
            5'd8:    atan_q20 = 30'sd234682;
            5'd9:    atan_q20 = 30'sd117342;
            5'd10:   atan_q20 = 30'sd58671;
            5'd11:   atan_q20 = 30'sd29335;
            5'd12:   atan_q20 = 30'sd14668;
            5'd13:   atan_q20 = 30'sd7334;
            5'd14:   atan_q20 = 30'sd3667;
            5'd15:   atan_q20 = 30'sd1833;
            5'd16:   atan_q20 = 30'sd917;
            5'd17:   atan_q20 = 30'sd458;
            5'd18:   atan_q20 = 30'sd229;
            5'd19:   atan_q20 = 30'sd115;
            5'd20:   atan_q20 = 30'sd57;
            5'd21:   atan_q20 = 30'sd29;
            5'd22:   atan_q20 = 30'sd14;
            5'd23:   atan_q20 = 30'sd7;
            default: atan_q20 = '0;
        endcase
    endfunction

    function automatic cos_lane_t cos_init(input logic signed [LATQ_W-1:0] lat_q,
                                           input logic signed [LATQ_W-1:0] lon_q);
        cos_lane_t r;
        logic signed [AZ_W-1:0] z;
        z = AZ_W'(lat_q) <<< ANG_SHIFT;
        if (z < 0) begin
            z = -z;
        end
        r.neg = 1'b0;
        // Beyond ninety degrees the cosine is taken as minus that of the supplement.
        if (z > Z_NINETY) begin
            z     = Z_ONE80 - z;
            r.neg = 1'b1;
        end
        r.z      = z;
        r.x      = GAIN_Q30;
        r.y      = '0;
        r.lon111 = PROJ_W'(lon_q) * KM_PER_DEG;
        r.yp     = PROJ_W'(lat_q) * KM_PER_DEG;
        return r;
    endfunction

    function automatic cos_lane_t cos_step(input cos_lane_t a, input logic [4:0] k);
        cos_lane_t r;
        logic signed [CX_W-1:0] xs;
        logic signed [CX_W-1:0] ys;
        r  = a;
        xs = a.x >>> k;
        ys = a.y >>> k;
        if (a.z >= 0) begin
            r.x = a.x - ys;
            r.y = a.y + xs;
            r.z = a.z - atan_q20(k);
        end else begin
            r.x = a.x + ys;
            r.y = a.y - xs;
            r.z = a.z + atan_q20(k);
        end
        return r;
    endfunction

    function automatic atan_lane_t atan_init(input logic signed [DX_W-1:0] dx,
                                             input logic signed [DY_W-1:0] dy);
        atan_lane_t r;
        r.dx = dx;
        r.dy = dy;
        r.x  = AX_W'(dy) <<< MUL_SHIFT;
        r.y  = AX_W'(dx) <<< MUL_SHIFT;
        r.z  = '0;
        if (dy < 0) begin
            r.z = (dx >= 0) ? Z_ONE80 : -Z_ONE80;
            r.x = -r.x;
            r.y = -r.y;
        end
        // On an axis the bearing is known exactly and the rotation is ignored.
        r.spec = (dx == 0) || (dy == 0);
        if (dx == 0) begin
            r.sb = (dy < 0) ? B_ONE80 : '0;
        end else begin
            r.sb = (dx > 0) ? B_NINETY : -B_NINETY;
        end
        return r;
    endfunction

    function automatic atan_lane_t atan_step(input atan_lane_t a, input logic [4:0] k);
        atan_lane_t r;
        logic signed [AX_W-1:0] xs;
        logic signed [AX_W-1:0] ys;
        r  = a;
        xs = a.x >>> k;
        ys = a.y >>> k;
        if (a.y >= 0) begin
            r.x = a.x + ys;
            r.y = a.y - xs;
            r.z = a.z + atan_q20(k);
        end else begin
            r.x = a.x - ys;
            r.y = a.y + xs;
            r.z = a.z - atan_q20(k);
        end
        return r;
    endfunction

endpackage

[rtl/core/local_bearing_from_coordinates_top.sv]
// Throughput: one transaction per cycle; the unrolled cosine and arctangent CORDIC stages
// each hold one item, and the whole pipeline holds while a result waits on m_ready.
// Reset (aresetn low, synchronous): pipeline emptied, reference registers cleared to zero.
// cfg_ready is always high; configuration must be written while no transaction is in
// flight, and the block itself does not enforce this.
module local_bearing_from_coordinates_top
    import lbc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [8:0]               cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [7:0]        s_site_lat_degrees,
    input  logic [5:0]               s_site_lat_minutes,
    input  logic signed [8:0]        s_site_lon_degrees,
    input  logic [5:0]               s_site_lon_minutes,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DX_W-1:0]   m_east_offset,
    output logic signed [DY_W-1:0]   m_north_offset,
    output logic signed [BRG_W-1:0]  m_bearing,
    output logic [CLS_W-1:0]         m_compass_class,
    output logic [DEV_W-1:0]         m_deviation
);

    localparam int N     = CORDIC_STEPS;
    localparam int DEPTH = 2 * N + 8;

    localparam logic signed [XS_W:0]   DX_HI = (XS_W + 1)'(2 ** (DX_W - 1) - 1);
    localparam logic signed [XS_W:0]   DX_LO = -DX_HI - 1;
    localparam logic signed [PROJ_W:0] DY_HI = (PROJ_W + 1)'(2 ** (DY_W - 1) - 1);
    localparam logic signed [PROJ_W:0] DY_LO = -DY_HI - 1;
    localparam logic signed [AZ_W-ANG_SHIFT-1:0] BQ_HI = (AZ_W - ANG_SHIFT)'(B_ONE80);
    localparam logic signed [AZ_W-ANG_SHIFT-1:0] BQ_LO = -BQ_HI;
    localparam logic signed [AZ_W-1:0] Z_HALF = AZ_W'(2 ** (ANG_SHIFT - 1));
    localparam logic signed [PROD_W-1:0] P_HALF = PROD_W'(2 ** (MUL_SHIFT - 1));

    logic signed [7:0] ref_lat_deg_reg;
    logic [5:0]        ref_lat_min_reg;
    logic signed [8:0] ref_lon_deg_reg;
    logic [5:0]        ref_lon_min_reg;

    logic [DEPTH-1:0] valid_reg;
    logic             advance;

    logic signed [LATQ_W-1:0] site_lat_q_reg, site_lon_q_reg, ref_lat_q_reg, ref_lon_q_reg;
    cos_lane_t cos_site_reg [0:N];
    cos_lane_t cos_ref_reg  [0:N];
    cos_lane_t cos_site_next [1:N];
    cos_lane_t cos_ref_next  [1:N];

    logic signed [CS_W-1:0]   c_site_reg, c_ref_reg;
    logic signed [PROJ_W-1:0] pa_lon_site_reg, pa_lon_ref_reg, pa_yp_site_reg, pa_yp_ref_reg;
    logic signed [PROD_W-1:0] prod_site_reg, prod_ref_reg;
    logic signed [PROJ_W-1:0] pb_yp_site_reg, pb_yp_ref_reg;
    logic signed [DX_W-1:0]   dx_reg;
    logic signed [DY_W-1:0]   dy_reg;

    atan_lane_t atan_reg  [0:N];
    atan_lane_t atan_next [1:N];

    logic signed [BRG_W-1:0] b_reg;
    logic signed [DX_W-1:0]  r_dx_reg;
    logic signed [DY_W-1:0]  r_dy_reg;

    logic signed [DX_W-1:0]  out_dx_reg;
    logic signed [DY_W-1:0]  out_dy_reg;
    logic signed [BRG_W-1:0] out_b_reg;
    logic [CLS_W-1:0]        out_cls_reg;
    logic [DEV_W-1:0]        out_dev_reg;

    // Projection differences, saturation, bearing rounding and compass classification.
    logic signed [XS_W-1:0]   xs_site, xs_ref;
    logic signed [PROD_W-1:0] prod_site_r, prod_ref_r;
    logic signed [XS_W:0]     dx_raw;
    logic signed [PROJ_W:0]   dy_raw;
    logic signed [DX_W-1:0]   dx_sat;
    logic signed [DY_W-1:0]   dy_sat;
    logic signed [AZ_W-1:0]   z_round;
    logic signed [AZ_W-ANG_SHIFT-1:0] bq;
    logic signed [BRG_W-1:0]  b_next;
    logic [CLS_W-1:0]         cls_next;
    logic signed [BRG_W:0]    dev_wide;

    assign cfg_ready = 1'b1;
    assign advance   = !valid_reg[DEPTH-1] || m_ready;
    assign s_ready   = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_lat_deg_reg <= '0;
            ref_lat_min_reg <= '0;
            ref_lon_deg_reg <= '0;
            ref_lon_min_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_REF_LAT_DEG: ref_lat_deg_reg <= cfg_data[7:0];
                REG_REF_LAT_MIN: ref_lat_min_reg <= cfg_data[5:0];
                REG_REF_LON_DEG: ref_lon_deg_reg <= cfg_data;
                REG_REF_LON_MIN: ref_lon_min_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[DEPTH-2:0], s_valid};
        end
    end

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            always_comb begin
                cos_site_next[k+1] = cos_step(cos_site_reg[k], 5'(k));
                cos_ref_next[k+1]  = cos_step(cos_ref_reg[k], 5'(k));
                atan_next[k+1]     = atan_step(atan_reg[k], 5'(k));
            end
        end
    endgenerate

    always_comb begin
        prod_site_r = prod_site_reg + P_HALF;
        prod_ref_r  = prod_ref_reg + P_HALF;
        xs_site     = prod_site_r[PROD_W-1:MUL_SHIFT];
        xs_ref      = prod_ref_r[PROD_W-1:MUL_SHIFT];
        dx_raw      = (XS_W + 1)'(xs_site) - (XS_W + 1)'(xs_ref);
        dy_raw      = (PROJ_W + 1)'(pb_yp_site_reg) - (PROJ_W + 1)'(pb_yp_ref_reg);
        if (dx_raw > DX_HI) begin
            dx_sat = DX_HI[DX_W-1:0];
        end else if (dx_raw < DX_LO) begin
            dx_sat = DX_LO[DX_W-1:0];
        end else begin
            dx_sat = dx_raw[DX_W-1:0];
        end
        if (dy_raw > DY_HI) begin
            dy_sat = DY_HI[DY_W-1:0];
        end else if (dy_raw < DY_LO) begin
            dy_sat = DY_LO[DY_W-1:0];
        end else begin
            dy_sat = dy_raw[DY_W-1:0];
        end
    end

    always_comb begin
        z_round = atan_reg[N].z + Z_HALF;
        bq      = z_round[AZ_W-1:ANG_SHIFT];
        if (atan_reg[N].spec) begin
            b_next = atan_reg[N].sb;
        end else if (bq > BQ_HI) begin
            b_next = B_ONE80;
        end else if (bq < BQ_LO) begin
            b_next = -B_ONE80;
        end else begin
            b_next = bq[BRG_W-1:0];
        end
    end

    always_comb begin
        if (b_reg == 0) begin
            cls_next = CLS_N;
            dev_wide = '0;
        end else if (b_reg == B_NINETY) begin
            cls_next = CLS_E;
            dev_wide = (BRG_W + 1)'(B_NINETY);
        end else if (b_reg == -B_NINETY) begin
            cls_next = CLS_W_;
            dev_wide = (BRG_W + 1)'(B_NINETY);
        end else if (b_reg == B_ONE80 || b_reg == -B_ONE80) begin
            cls_next = CLS_S;
            dev_wide = '0;
        end else if (b_reg < 0 && b_reg > -B_NINETY) begin
            cls_next = CLS_NW;
            dev_wide = -(BRG_W + 1)'(b_reg);
        end else if (b_reg > 0 && b_reg < B_NINETY) begin
            cls_next = CLS_NE;
            dev_wide = (BRG_W + 1)'(b_reg);
        end else if (b_reg > B_NINETY) begin
            cls_next = CLS_SE;
            dev_wide = (BRG_W + 1)'(B_ONE80) - (BRG_W + 1)'(b_reg);
        end else begin
            cls_next = CLS_SW;
            dev_wide = (BRG_W + 1)'(B_ONE80) + (BRG_W + 1)'(b_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            site_lat_q_reg <= to_angle(9'(s_site_lat_degrees), s_site_lat_minutes);
            site_lon_q_reg <= to_angle(s_site_lon_degrees, s_site_lon_minutes);
            ref_lat_q_reg  <= to_angle(9'(ref_lat_deg_reg), ref_lat_min_reg);
            ref_lon_q_reg  <= to_angle(ref_lon_deg_reg, ref_lon_min_reg);

            cos_site_reg[0] <= cos_init(site_lat_q_reg, site_lon_q_reg);
            cos_ref_reg[0]  <= cos_init(ref_lat_q_reg, ref_lon_q_reg);
            for (int i = 1; i <= N; i++) begin
                cos_site_reg[i] <= cos_site_next[i];
                cos_ref_reg[i]  <= cos_ref_next[i];
            end

            c_site_reg      <= cos_site_reg[N].neg ? CS_W'(-cos_site_reg[N].x)
                                                   : CS_W'(cos_site_reg[N].x);
            c_ref_reg       <= cos_ref_reg[N].neg ? CS_W'(-cos_ref_reg[N].x)
                                                  : CS_W'(cos_ref_reg[N].x);
            pa_lon_site_reg <= cos_site_reg[N].lon111;
            pa_lon_ref_reg  <= cos_ref_reg[N].lon111;
            pa_yp_site_reg  <= cos_site_reg[N].yp;
            pa_yp_ref_reg   <= cos_ref_reg[N].yp;

            prod_site_reg  <= PROD_W'(pa_lon_site_reg) * PROD_W'(c_site_reg);
            prod_ref_reg   <= PROD_W'(pa_lon_ref_reg) * PROD_W'(c_ref_reg);
            pb_yp_site_reg <= pa_yp_site_reg;
            pb_yp_ref_reg  <= pa_yp_ref_reg;

            dx_reg <= dx_sat;
            dy_reg <= dy_sat;

            atan_reg[0] <= atan_init(dx_reg, dy_reg);
            for (int i = 1; i <= N; i++) begin
                atan_reg[i] <= atan_next[i];
            end

            b_reg    <= b_next;
            r_dx_reg <= atan_reg[N].dx;
            r_dy_reg <= atan_reg[N].dy;

            out_dx_reg  <= r_dx_reg;
            out_dy_reg  <= r_dy_reg;
            out_b_reg   <= b_reg;
            out_cls_reg <= cls_next;
            out_dev_reg <= dev_wide[DEV_W-1:0];
        end
    end

    assign m_valid         = valid_reg[DEPTH-1];
    assign m_east_offset   = out_dx_reg;
    assign m_north_offset  = out_dy_reg;
    assign m_bearing       = out_b_reg;
    assign m_compass_class = out_cls_reg;
    assign m_deviation     = out_dev_reg;

endmodule
